// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL. Each macro expects signals named clk and rst_n
// in the module where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define QSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("qsd assertion failed");
`define QSD_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("qsd forbidden condition seen");
`else
`define QSD_ASSERT(lbl, prop)
`define QSD_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ===== sv/qsd_pkg.sv =====
package qsd_pkg;

  localparam int QSD_IN_WIDTH  = 16;
  localparam int QSD_OUT_WIDTH = 16;

  // Fixed point: input Q12, scale Q16, soft values Q8.
  localparam int IN_FRAC    = 12;
  localparam int SCALE_FRAC = 16;
  localparam int OUT_FRAC   = 8;
  localparam int KSHIFT     = IN_FRAC + SCALE_FRAC - OUT_FRAC;
  localparam int KHALF      = 1 << (KSHIFT - 1);
  localparam int ONE_Q8     = 1 << OUT_FRAC;

  localparam int KW = 19;
  typedef logic [KW-1:0] qsd_scale_t;

  typedef logic [1:0] qsd_mode_t;
  localparam qsd_mode_t MOD_QPSK  = 2'd0;
  localparam qsd_mode_t MOD_16QAM = 2'd1;
  localparam qsd_mode_t MOD_64QAM = 2'd2;
  localparam qsd_mode_t MOD_RSVD  = 2'd3;

  localparam int MAX_PAIRS = 3;
  typedef logic [1:0] qsd_count_t;

  typedef struct packed {
    logic s2;
    logic s3;
  } qsd_stage_en_t;

  // sqrt(2), sqrt(10), sqrt(42) in unsigned Q16, rounded to nearest.
  function automatic qsd_scale_t scale_of(input qsd_mode_t mode);
    qsd_scale_t k;
    unique case (mode)
      MOD_16QAM: k = 19'd207243;
      MOD_64QAM: k = 19'd424722;
      default:   k = 19'd92682;
    endcase
    return k;
  endfunction

  function automatic qsd_count_t pairs_of(input qsd_mode_t mode);
    qsd_count_t n;
    unique case (mode)
      MOD_16QAM: n = 2'd2;
      MOD_64QAM: n = 2'd3;
      default:   n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/qsd_sym_if.sv =====
interface qsd_sym_if #(
  parameter int W = qsd_pkg::QSD_IN_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sym_i;
  logic signed [W-1:0] sym_q;

  modport source (output valid, output sym_i, output sym_q, input ready);
  modport sink   (input valid, input sym_i, input sym_q, output ready);
endinterface

// ===== sv/qsd_soft_if.sv =====
interface qsd_soft_if #(
  parameter int W = qsd_pkg::QSD_OUT_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] soft_i;
  logic signed [W-1:0] soft_q;
  logic                last_pair;

  modport source (output valid, output soft_i, output soft_q, output last_pair, input ready);
  modport sink   (input valid, input soft_i, input soft_q, input last_pair, output ready);
endinterface

// ===== sv/qsd_axis.sv =====
module qsd_axis #(
  parameter int IN_WIDTH  = qsd_pkg::QSD_IN_WIDTH,
  parameter int OUT_WIDTH = qsd_pkg::QSD_OUT_WIDTH
) (
  input  logic                        clk,
  input  qsd_pkg::qsd_stage_en_t      en,
  input  logic signed [IN_WIDTH-1:0]  x,
  input  qsd_pkg::qsd_scale_t         k,
  input  qsd_pkg::qsd_mode_t          mode,
  output logic signed [OUT_WIDTH-1:0] soft_val [qsd_pkg::MAX_PAIRS]
);
  import qsd_pkg::*;

  localparam int PW = IN_WIDTH + KW + 1;
  localparam int CW = IN_WIDTH;
  localparam int BW = IN_WIDTH + 4;
  localparam int SW = ((BW > OUT_WIDTH) ? BW : OUT_WIDTH) + 1;

  logic signed [PW-1:0] prod_nxt, prod_r;
  logic signed [PW-1:0] rnd, sum, shifted;
  logic signed [CW-1:0] c_nxt, c_r;
  logic signed [BW-1:0] ce, a, m64;
  logic signed [BW-1:0] b0, b1, b2;
  logic                 pos;
  logic signed [BW-1:0] two, four, six, ten, twelve;

  function automatic logic signed [OUT_WIDTH-1:0] sat(input logic signed [BW-1:0] v);
    logic signed [SW-1:0] w, hi, lo;
    logic signed [OUT_WIDTH-1:0] r;
    w  = SW'(v);
    hi = {{(SW-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
    lo = ~hi;
    if (w > hi) begin
      r = hi[OUT_WIDTH-1:0];
    end else if (w < lo) begin
      r = lo[OUT_WIDTH-1:0];
    end else begin
      r = w[OUT_WIDTH-1:0];
    end
    return r;
  endfunction

  assign prod_nxt = x * $signed({1'b0, k});

  // Round half away from zero: a negative product takes one less than half.
  assign rnd     = prod_r[PW-1] ? PW'(KHALF - 1) : PW'(KHALF);
  assign sum     = prod_r + rnd;
  assign shifted = sum >>> KSHIFT;
  assign c_nxt   = shifted[CW-1:0];

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_r <= prod_nxt;
    end
    if (en.s3) begin
      c_r <= c_nxt;
    end
  end

  assign two    = BW'(2 * ONE_Q8);
  assign four   = BW'(4 * ONE_Q8);
  assign six    = BW'(6 * ONE_Q8);
  assign ten    = BW'(10 * ONE_Q8);
  assign twelve = BW'(12 * ONE_Q8);

  assign ce  = BW'(c_r);
  assign a   = c_r[CW-1] ? -ce : ce;
  assign pos = !c_r[CW-1] && (c_r != '0);

  always_comb begin
    if (a <= four) begin
      m64 = (a <<< 1) - two;
    end else if (a <= six) begin
      m64 = a + (a <<< 1) - six;
    end else begin
      m64 = (a <<< 2) - twelve;
    end
  end

  always_comb begin
    b0 = -ce;
    b1 = '0;
    b2 = '0;
    unique case (mode)
      MOD_16QAM: begin
        if (a >= two) begin
          b0 = pos ? (two - (a <<< 1)) : ((a <<< 1) - two);
        end
        b1 = a - two;
      end
      MOD_64QAM: begin
        if (a > two) begin
          b0 = pos ? -m64 : m64;
        end
        if (a <= two) begin
          b1 = (a <<< 1) - six;
        end else if (a <= six) begin
          b1 = a - four;
        end else begin
          b1 = (a <<< 1) - ten;
        end
        b2 = (a <= four) ? (two - a) : (a - six);
      end
      default: begin
        b0 = -ce;
      end
    endcase
  end

  assign soft_val[0] = sat(b0);
  assign soft_val[1] = sat(b1);
  assign soft_val[2] = sat(b2);

endmodule

// ===== sv/qam_soft_demapper.sv =====
// A symbol's word passes the input, product and rounded-value registers and the serializer
// before its first pair reaches out_soft. While out_soft is ready, QPSK takes one symbol per
// cycle; the serializer sends one pair a cycle, loading a new symbol as the last pair leaves.
// Reset: rst_n is synchronous and active low; it empties the pipeline and sets QPSK.
`include "assert_macros.svh"

module qam_soft_demapper #(
  parameter int IN_WIDTH  = qsd_pkg::QSD_IN_WIDTH,
  parameter int OUT_WIDTH = qsd_pkg::QSD_OUT_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  qsd_sym_if.sink            in_sym,
  qsd_soft_if.source         out_soft,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import qsd_pkg::*;

  // The block is a four-stage pipeline. Stage 1 holds the accepted symbol word,
  // stage 2 the scaled products, stage 3 the rounded axis values, and stage 4 is
  // a small serializer holding every soft pair of one symbol. Each stage moves
  // forward when the stage after it is empty or is itself moving, so a stall on
  // the output only backs up as far as it has to.

  // Configuration register. Any address whose index bit is clear maps to the
  // modulation select register.
  qsd_mode_t mod_sel_r, mod_sel_nxt;
  logic      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

  always_comb begin
    mod_sel_nxt = mod_sel_r;
    if (cfg_wr) begin
      mod_sel_nxt = pwdata[1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {30'd0, mod_sel_r};

  // Pipeline control.
  logic          v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic          in_fire, out_fire, ld4;
  qsd_stage_en_t en;
  qsd_count_t    cnt_r, cnt_nxt;
  qsd_mode_t     mode1_r, mode2_r, mode3_r;

  assign out_fire = out_soft.valid && out_soft.ready;

  // The serializer takes a new symbol when empty, or in the cycle its last word leaves.
  assign ld4  = v3_r && ((cnt_r == 2'd0) || (out_fire && (cnt_r == 2'd1)));
  assign en.s3 = v2_r && (!v3_r || ld4);
  assign en.s2 = v1_r && (!v2_r || en.s3);

  assign in_sym.ready = !v1_r || en.s2;
  assign in_fire      = in_sym.valid && in_sym.ready;

  assign v1_nxt = in_fire ? 1'b1 : (en.s2 ? 1'b0 : v1_r);
  assign v2_nxt = en.s2   ? 1'b1 : (en.s3 ? 1'b0 : v2_r);
  assign v3_nxt = en.s3   ? 1'b1 : (ld4   ? 1'b0 : v3_r);

  always_comb begin
    cnt_nxt = cnt_r;
    if (ld4) begin
      cnt_nxt = pairs_of(mode3_r);
    end else if (out_fire) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_sel_r <= MOD_QPSK;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      cnt_r     <= '0;
    end else begin
      mod_sel_r <= mod_sel_nxt;
      v1_r      <= v1_nxt;
      v2_r      <= v2_nxt;
      v3_r      <= v3_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // Payload of stage 1 and the mode carried beside the data. The reserved
  // select code is treated as QPSK when the symbol is taken.
  logic signed [IN_WIDTH-1:0] sym_i1_r, sym_q1_r;
  qsd_scale_t                 k1;

  assign k1 = scale_of(mode1_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sym_i1_r <= in_sym.sym_i;
      sym_q1_r <= in_sym.sym_q;
      mode1_r  <= (mod_sel_r == MOD_RSVD) ? MOD_QPSK : mod_sel_r;
    end
    if (en.s2) begin
      mode2_r <= mode1_r;
    end
    if (en.s3) begin
      mode3_r <= mode2_r;
    end
  end

  // Stages 2 and 3 of each axis.
  logic signed [OUT_WIDTH-1:0] soft_i3 [MAX_PAIRS];
  logic signed [OUT_WIDTH-1:0] soft_q3 [MAX_PAIRS];

  qsd_axis #(.IN_WIDTH(IN_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_axis_i (
    .clk      (clk),
    .en       (en),
    .x        (sym_i1_r),
    .k        (k1),
    .mode     (mode3_r),
    .soft_val (soft_i3)
  );

  qsd_axis #(.IN_WIDTH(IN_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_axis_q (
    .clk      (clk),
    .en       (en),
    .x        (sym_q1_r),
    .k        (k1),
    .mode     (mode3_r),
    .soft_val (soft_q3)
  );

  // Serializer: slot 0 drives the output word; each accepted word shifts the
  // remaining pairs down by one slot.
  logic signed [OUT_WIDTH-1:0] si_r [MAX_PAIRS];
  logic signed [OUT_WIDTH-1:0] sq_r [MAX_PAIRS];

  always_ff @(posedge clk) begin
    if (ld4) begin
      for (int j = 0; j < MAX_PAIRS; j++) begin
        si_r[j] <= soft_i3[j];
        sq_r[j] <= soft_q3[j];
      end
    end else if (out_fire) begin
      for (int j = 0; j < MAX_PAIRS - 1; j++) begin
        si_r[j] <= si_r[j+1];
        sq_r[j] <= sq_r[j+1];
      end
    end
  end

  assign out_soft.valid     = (cnt_r != 2'd0);
  assign out_soft.soft_i    = si_r[0];
  assign out_soft.soft_q    = sq_r[0];
  assign out_soft.last_pair = (cnt_r == 2'd1);

  // The serializer is never overwritten while pairs of the previous symbol remain.
  `QSD_ASSERT(a_load_when_free, ld4 |-> ((cnt_r == 2'd0) || (out_fire && (cnt_r == 2'd1))))
  // A word that leaves with more behind it reduces the count by exactly one.
  `QSD_ASSERT(a_count_steps, (out_fire && (cnt_r > 2'd1)) |=> (cnt_r == $past(cnt_r) - 2'd1))
  // The reserved select code never reaches the datapath.
  `QSD_ASSERT_NEVER(a_no_rsvd_mode, v1_r && (mode1_r == MOD_RSVD))
  // An accepted symbol always lands in stage 1.
  `QSD_ASSERT(a_in_lands, in_fire |=> v1_r)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the soft demapper. Symbols go in on the sym channel,
// soft pairs come out on the soft channel, and an internal model of the
// piecewise-linear rules predicts every pair. The mode register is only
// touched while the pipeline is empty.
module tb;
  import qsd_pkg::*;

  // Register map: mod_select is the only register, at byte address zero.
  localparam logic [2:0] ADDR_MOD_SELECT = 3'd0;

  // Scale factors sqrt(2), sqrt(10) and sqrt(42) as unsigned Q16 numbers.
  localparam longint SQRT2_Q16  = 92682;
  localparam longint SQRT10_Q16 = 207243;
  localparam longint SQRT42_Q16 = 424722;

  // One unit of the integer constellation grid in Q8.
  localparam longint GRID = 256;

  localparam longint SOFT_MAX = 32767;
  localparam longint SOFT_MIN = -32768;

  typedef struct {
    logic signed [15:0] soft_i;
    logic signed [15:0] soft_q;
    logic               last_pair;
  } soft_pair_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  qsd_sym_if  sym_if ();
  qsd_soft_if soft_if ();

  qam_soft_demapper i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_sym   (sym_if),
    .out_soft (soft_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // The bench's own copy of the mode register, updated on every write.
  qsd_mode_t  model_mode;
  soft_pair_t expected_pairs[$];

  // When set, neither the sender nor the receiver inserts random gaps.
  bit no_idle;

  int error_count;
  int pairs_checked;
  int symbols_sent;
  int mode_symbols[4];

  // The clock starts low so that the first rising edge comes after time zero.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // The reserved selector value decodes as QPSK.
  function automatic qsd_mode_t effective_mode(input qsd_mode_t mode);
    return (mode == MOD_RSVD) ? MOD_QPSK : mode;
  endfunction

  function automatic longint grid_scale(input qsd_mode_t mode);
    case (effective_mode(mode))
      MOD_16QAM: return SQRT10_Q16;
      MOD_64QAM: return SQRT42_Q16;
      default:   return SQRT2_Q16;
    endcase
  endfunction

  function automatic int bits_per_axis(input qsd_mode_t mode);
    case (effective_mode(mode))
      MOD_16QAM: return 2;
      MOD_64QAM: return 3;
      default:   return 1;
    endcase
  endfunction

  // Q12 sample times the Q16 scale gives Q28; dropping 20 bits with the
  // magnitude rounded half away from zero leaves the grid coordinate in Q8.
  function automatic longint grid_coord(input logic signed [15:0] x, input qsd_mode_t mode);
    longint prod;
    longint mag;
    prod = longint'(x) * grid_scale(mode);
    mag  = (prod < 0) ? -prod : prod;
    mag  = (mag + (longint'(1) <<< (KSHIFT - 1))) >>> KSHIFT;
    return (prod < 0) ? -mag : mag;
  endfunction

  // Piecewise-linear soft value of one bit position on one axis. The sign of
  // a zero coordinate counts as negative.
  function automatic longint axis_soft(input qsd_mode_t mode, input longint c, input int bitpos);
    longint a;
    longint s;
    a = (c < 0) ? -c : c;
    s = (c > 0) ? 1 : -1;
    case (effective_mode(mode))
      MOD_16QAM: begin
        if (bitpos == 0) return (a < 2 * GRID) ? -c : s * (2 * GRID - 2 * a);
        return a - 2 * GRID;
      end
      MOD_64QAM: begin
        if (bitpos == 0) begin
          if (a <= 2 * GRID) return -c;
          if (a <= 4 * GRID) return -s * (2 * a - 2 * GRID);
          if (a <= 6 * GRID) return -s * (3 * a - 6 * GRID);
          return -s * (4 * a - 12 * GRID);
        end
        if (bitpos == 1) begin
          if (a <= 2 * GRID) return 2 * a - 6 * GRID;
          if (a <= 6 * GRID) return a - 4 * GRID;
          return 2 * a - 10 * GRID;
        end
        return (a <= 4 * GRID) ? 2 * GRID - a : a - 6 * GRID;
      end
      default: return -c;
    endcase
  endfunction

  function automatic logic signed [15:0] saturate_soft(input longint v);
    if (v > SOFT_MAX) return 16'sh7fff;
    if (v < SOFT_MIN) return 16'sh8000;
    return v[15:0];
  endfunction

  // Appends the pairs that one accepted symbol must produce, in output order.
  function automatic void predict_soft_pairs(input logic signed [15:0] si,
                                             input logic signed [15:0] sq);
    longint     ci;
    longint     cq;
    int         nbits;
    soft_pair_t pair;
    ci    = grid_coord(si, model_mode);
    cq    = grid_coord(sq, model_mode);
    nbits = bits_per_axis(model_mode);
    for (int b = 0; b < nbits; b++) begin
      pair.soft_i    = saturate_soft(axis_soft(model_mode, ci, b));
      pair.soft_q    = saturate_soft(axis_soft(model_mode, cq, b));
      pair.last_pair = (b == nbits - 1);
      expected_pairs.push_back(pair);
    end
  endfunction

  // Finds a sample that lands exactly on a given grid coordinate, so that the
  // threshold comparisons can be probed at their boundaries.
  function automatic logic signed [15:0] sample_for(input qsd_mode_t mode, input longint target);
    longint x0;
    x0 = (target <<< KSHIFT) / grid_scale(mode);
    for (longint d = -2; d <= 2; d++) begin
      if (grid_coord(16'(x0 + d), mode) == target) return 16'(x0 + d);
    end
    return 16'(x0);
  endfunction

  // Most samples stay near the constellation, where the rules have their
  // corners; the rest span the whole input range and drive saturation.
  function automatic logic signed [15:0] random_sample();
    int v;
    if ($urandom_range(99) < 70) begin
      v = int'($urandom_range(12000)) - 6000;
      return v[15:0];
    end
    v = $urandom;
    return v[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // valid stays high after a word is taken, so back-to-back words never see
  // a lowered and re-raised valid within one time step.
  task automatic send_symbol(input logic signed [15:0] si, input logic signed [15:0] sq);
    while (!no_idle && $urandom_range(99) < 30) begin
      sym_if.valid <= 1'b0;
      @(posedge clk);
    end
    sym_if.valid <= 1'b1;
    sym_if.sym_i <= si;
    sym_if.sym_q <= sq;
    do @(posedge clk); while (!sym_if.ready);
    predict_soft_pairs(si, sq);
    symbols_sent++;
    mode_symbols[model_mode]++;
  endtask

  // Lowers valid and waits for every predicted pair, then lets the pipeline settle.
  task automatic wait_for_drain();
    sym_if.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input logic [2:0] addr, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("mod_select readback: expected %0d, got %0d", want, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Mode changes happen only with an empty pipeline.
  task automatic set_mode(input qsd_mode_t mode);
    wait_for_drain();
    write_register(ADDR_MOD_SELECT, 32'(mode));
    model_mode = mode;
    check_register(ADDR_MOD_SELECT, 32'(mode));
  endtask

  // After reset the block must demap as QPSK without any register write.
  task automatic test_reset_mode();
    check_register(ADDR_MOD_SELECT, 32'(MOD_QPSK));
    send_symbol(16'sd2896, -16'sd2896);
    send_symbol(-16'sd100, 16'sd7);
  endtask

  // Both extremes of each field, a zero symbol and the smallest nonzero
  // values, in every mode including the reserved selector.
  task automatic test_field_extremes();
    qsd_mode_t modes[4];
    modes = '{MOD_QPSK, MOD_16QAM, MOD_64QAM, MOD_RSVD};
    foreach (modes[m]) begin
      set_mode(modes[m]);
      send_symbol(16'sh7fff, 16'sh8000);
      send_symbol(16'sh8000, 16'sh7fff);
      send_symbol(16'sd0, 16'sd0);
      send_symbol(16'sd1, -16'sd1);
    end
  endtask

  // Symbols placed exactly on the grid points where a rule changes slope.
  task automatic test_threshold_points();
    set_mode(MOD_16QAM);
    send_symbol(sample_for(MOD_16QAM, 2 * GRID), sample_for(MOD_16QAM, -2 * GRID));
    set_mode(MOD_64QAM);
    for (int t = 2; t <= 6; t += 2)
      send_symbol(sample_for(MOD_64QAM, t * GRID), sample_for(MOD_64QAM, -t * GRID));
  endtask

  // The sender stops until every pair is out, then resumes into a pipeline
  // that has gone completely empty.
  task automatic test_sender_pause();
    set_mode(MOD_64QAM);
    repeat (6) send_symbol(random_sample(), random_sample());
    sym_if.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (6) send_symbol(random_sample(), random_sample());
  endtask

  // Random symbols through each mode in turn. In the second 64QAM phase the
  // first half runs with no gaps on either side to keep the serializer full.
  task automatic test_random_traffic();
    qsd_mode_t modes[5];
    modes = '{MOD_QPSK, MOD_16QAM, MOD_64QAM, MOD_RSVD, MOD_64QAM};
    foreach (modes[m]) begin
      set_mode(modes[m]);
      for (int n = 0; n < 32; n++) begin
        no_idle = (m == 4) && (n < 16);
        send_symbol(random_sample(), random_sample());
      end
      no_idle = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // The receiver stalls at random, except while the no-idle stretch runs.
  initial begin
    soft_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      soft_if.ready <= no_idle || ($urandom_range(99) >= 30);
    end
  end

  // Every pair taken from the block is matched against the oldest prediction.
  always @(posedge clk) begin : check_pairs
    soft_pair_t want;
    if (rst_n && soft_if.valid && soft_if.ready) begin
      if (expected_pairs.size() == 0) begin
        $error("soft pair with no symbol pending: soft_i %0d soft_q %0d last_pair %0b",
               soft_if.soft_i, soft_if.soft_q, soft_if.last_pair);
        error_count++;
      end else begin
        want = expected_pairs.pop_front();
        pairs_checked++;
        if (soft_if.soft_i !== want.soft_i) begin
          $error("soft_i: expected %0d, got %0d", want.soft_i, soft_if.soft_i);
          error_count++;
        end
        if (soft_if.soft_q !== want.soft_q) begin
          $error("soft_q: expected %0d, got %0d", want.soft_q, soft_if.soft_q);
          error_count++;
        end
        if (soft_if.last_pair !== want.last_pair) begin
          $error("last_pair: expected %0b, got %0b", want.last_pair, soft_if.last_pair);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    no_idle      = 1'b0;
    model_mode   = MOD_QPSK;
    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= ADDR_MOD_SELECT;
    pwdata       <= '0;
    sym_if.valid <= 1'b0;
    sym_if.sym_i <= '0;
    sym_if.sym_q <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_mode();
    test_field_extremes();
    test_threshold_points();
    test_sender_pause();
    test_random_traffic();

    wait_for_drain();
    $display("Sent %0d symbols (QPSK %0d, 16QAM %0d, 64QAM %0d, reserved %0d);",
             symbols_sent, mode_symbols[MOD_QPSK], mode_symbols[MOD_16QAM],
             mode_symbols[MOD_64QAM], mode_symbols[MOD_RSVD]);
    $display("checked %0d soft pairs against the predicted values.", pairs_checked);
    if (error_count == 0) begin
      $display("qam_soft_demapper test passed");
    end else begin
      $display("qam_soft_demapper test failed");
    end
    $finish;
  end

  // This bound only catches hangs; a healthy run finishes long before it.
  initial begin
    #2000000;
    $display("qam_soft_demapper test failed");
    $finish;
  end

endmodule

// ===== qam_soft_demapper.f =====
+incdir+sv
sv/qsd_pkg.sv
sv/qsd_sym_if.sv
sv/qsd_soft_if.sv
sv/qsd_axis.sv
sv/qam_soft_demapper.sv
tb/tb.sv
